// ===== rtl/core/cebb_pkg.sv =====
package cebb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 15;
    localparam int MAX_HEIGHT = 1024;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int PW  = XW + YW + 1;
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int SRW = RW + 1;
    localparam int RB  = $clog2(2 * MAX_RADIUS + 1);
    localparam int AW  = RB + XW;
    localparam int CH  = 16;
    localparam int NL  = 3;
    localparam int DV  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SW  = CH + DV;
    localparam int CW  = $clog2(SW);

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam logic OP_PIXEL = 1'b0;

    typedef struct packed {
        logic clear;
        logic acc;
        logic step;
    } t_lane_ctrl;

    typedef struct packed {
        logic load;
        logic last;
    } t_out_ctrl;

    function automatic logic [XW:0] sat_width(input logic [10:0] v);
        if (v == 11'd0) begin
            return (XW + 1)'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            return (XW + 1)'(MAX_WIDTH);
        end
        return (XW + 1)'(v);
    endfunction

    function automatic logic [YW:0] sat_height(input logic [10:0] v);
        if (v == 11'd0) begin
            return (YW + 1)'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            return (YW + 1)'(MAX_HEIGHT);
        end
        return (YW + 1)'(v);
    endfunction

    function automatic logic [RW-1:0] sat_radius(input logic [3:0] v);
        if (int'(v) > MAX_RADIUS) begin
            return RW'(MAX_RADIUS);
        end
        return RW'(v);
    endfunction

endpackage

// ===== rtl/core/cebb_lane.sv =====
module cebb_lane (
    input  logic                        i_clk,
    input  cebb_pkg::t_lane_ctrl        i_ctrl,
    input  logic [cebb_pkg::CH-1:0]     i_pix,
    input  logic [cebb_pkg::DV-1:0]     i_divisor,
    output logic [cebb_pkg::CH-1:0]     o_mean
);

    logic [cebb_pkg::SW-1:0] r_q;
    logic [cebb_pkg::DV-1:0] r_rem;
    logic [cebb_pkg::DV:0]   rem_sh;
    logic [cebb_pkg::DV:0]   rem_sub;

    // The accumulator doubles as the dividend shift register.
    assign rem_sh  = {r_rem, r_q[cebb_pkg::SW-1]};
    assign rem_sub = rem_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_q   <= '0;
            r_rem <= '0;
        end else if (i_ctrl.acc) begin
            r_q <= r_q + cebb_pkg::SW'(i_pix);
        end else if (i_ctrl.step) begin
            if (rem_sh >= {1'b0, i_divisor}) begin
                r_rem <= rem_sub[cebb_pkg::DV-1:0];
                r_q   <= {r_q[cebb_pkg::SW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[cebb_pkg::DV-1:0];
                r_q   <= {r_q[cebb_pkg::SW-2:0], 1'b0};
            end
        end
    end

    assign o_mean = r_q[cebb_pkg::CH-1:0];

endmodule

// ===== rtl/core/cebb_out.sv =====
module cebb_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cebb_pkg::t_out_ctrl               i_ctrl,
    input  logic [cebb_pkg::NL*cebb_pkg::CH-1:0] i_means,
    output logic                              o_free,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cebb_pkg::NL*cebb_pkg::CH-1:0] m_axis_tdata,
    output logic                              m_axis_tlast
);

    logic                                  r_vld;
    logic [cebb_pkg::NL*cebb_pkg::CH-1:0]  r_data;
    logic                                  r_last;

    assign o_free = !r_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctrl.load) begin
            r_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_data <= i_means;
            r_last <= i_ctrl.last;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;

endmodule

// ===== rtl/core/clamped_edge_box_blur_core.sv =====
// Box blur with clamp-to-edge over one RGB frame streamed in scan order.
// Set width, height and radius through the configuration channel while the
// block is idle; a write to any of these three restarts the frame. Output
// pixel k leaves after input pixel k + r*W + r, and flush items (tuser = 1)
// drain the last outputs of the frame. While an item that gives an output
// is worked on and its result waits for the output register, no input is
// taken: the window is read one pixel per cycle through the single read
// port of the row store, the three channel lanes accumulate side by side,
// and each lane then divides by (2r+1)^2 one quotient bit per cycle. The
// row store holds the last 32 rows and needs no clearing pass.
module clamped_edge_box_blur_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // red_in, green_in, blue_in
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // red_out, green_out, blue_out
    output logic        m_axis_tlast,  // frame_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int XW  = cebb_pkg::XW;
    localparam int YW  = cebb_pkg::YW;
    localparam int PW  = cebb_pkg::PW;
    localparam int RW  = cebb_pkg::RW;
    localparam int SRW = cebb_pkg::SRW;
    localparam int RB  = cebb_pkg::RB;
    localparam int AW  = cebb_pkg::AW;
    localparam int CH  = cebb_pkg::CH;
    localparam int NL  = cebb_pkg::NL;
    localparam int DV  = cebb_pkg::DV;
    localparam int SW  = cebb_pkg::SW;
    localparam int CW  = cebb_pkg::CW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CALC  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_LOAD  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [10:0] r_cfg_w, r_cfg_h;
    logic [3:0]  r_cfg_r;

    logic [XW:0]   w_eff;
    logic [YW:0]   h_eff;
    logic [RW-1:0] r_eff;
    logic [PW-1:0] total;
    logic [PW-1:0] delay;
    logic [DV-1:0] divisor;

    logic [PW-1:0] r_in_pos, r_out_pos;
    logic [XW-1:0] r_in_x, r_out_x;
    logic [YW-1:0] r_in_y, r_out_y;
    logic signed [SRW-1:0] r_dx, r_dy;
    logic [CW-1:0] r_cnt;
    logic          r_rd_vld;

    logic [NL*CH-1:0] mem [2**AW];
    logic [NL*CH-1:0] r_rd_data;

    logic in_acc, cfg_acc, cfg_hit;
    logic pix_ok, emit, wr_en;
    logic last_issue, out_free, frame_done;

    logic signed [YW+1:0] ry;
    logic signed [XW+1:0] cx;
    logic [YW-1:0] row_sel;
    logic [XW-1:0] col_sel;
    logic [AW-1:0] raddr, waddr;

    cebb_pkg::t_lane_ctrl lane_ctrl;
    cebb_pkg::t_out_ctrl  out_ctrl;
    logic [NL*CH-1:0]     means;

    assign w_eff   = cebb_pkg::sat_width(r_cfg_w);
    assign h_eff   = cebb_pkg::sat_height(r_cfg_h);
    assign r_eff   = cebb_pkg::sat_radius(r_cfg_r);
    assign total   = PW'(w_eff) * PW'(h_eff);
    assign delay   = PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    assign divisor = DV'((2 * r_eff + 1) * (2 * r_eff + 1));

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign cfg_hit = cfg_acc && (i_cfg_index == cebb_pkg::CFG_WIDTH
                              || i_cfg_index == cebb_pkg::CFG_HEIGHT
                              || i_cfg_index == cebb_pkg::CFG_RADIUS);

    // A pixel past the end of the frame is treated as a flush.
    assign pix_ok = (s_axis_tuser == cebb_pkg::OP_PIXEL) && (r_in_pos < total);
    assign emit   = (r_out_pos < total) && (pix_ok ? (r_in_pos >= delay)
                                                   : (r_in_pos >= total));
    assign wr_en  = in_acc && pix_ok;
    assign waddr  = {r_in_y[RB-1:0], r_in_x};

    // Window coordinates clamped to the frame.
    assign ry = $signed({2'b00, r_out_y}) + $signed({{(YW+2-SRW){r_dy[SRW-1]}}, r_dy});
    assign cx = $signed({2'b00, r_out_x}) + $signed({{(XW+2-SRW){r_dx[SRW-1]}}, r_dx});

    always_comb begin
        if (ry[YW+1]) begin
            row_sel = '0;
        end else if (ry > $signed({1'b0, h_eff}) - 1) begin
            row_sel = YW'(h_eff - 1'b1);
        end else begin
            row_sel = ry[YW-1:0];
        end
        if (cx[XW+1]) begin
            col_sel = '0;
        end else if (cx > $signed({1'b0, w_eff}) - 1) begin
            col_sel = XW'(w_eff - 1'b1);
        end else begin
            col_sel = cx[XW-1:0];
        end
    end

    assign raddr = {row_sel[RB-1:0], col_sel};
    assign last_issue = (r_dx == $signed({1'b0, r_eff}))
                     && (r_dy == $signed({1'b0, r_eff}));
    assign frame_done = (r_out_pos + 1'b1) >= total;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= s_axis_tdata;
        end
        r_rd_data <= mem[raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && emit) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CW'(SW - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg_w  <= 11'd1024;
            r_cfg_h  <= 11'd1024;
            r_cfg_r  <= 4'd3;
            r_in_pos <= '0;
            r_out_pos <= '0;
            r_in_x   <= '0;
            r_in_y   <= '0;
            r_out_x  <= '0;
            r_out_y  <= '0;
            r_rd_vld <= 1'b0;
            r_cnt    <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_CALC);
            if (cfg_acc) begin
                case (i_cfg_index)
                    cebb_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                    cebb_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                    cebb_pkg::CFG_RADIUS: r_cfg_r <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_in_pos  <= '0;
                r_out_pos <= '0;
                r_in_x    <= '0;
                r_in_y    <= '0;
                r_out_x   <= '0;
                r_out_y   <= '0;
            end else if (wr_en) begin
                r_in_pos <= r_in_pos + 1'b1;
                if ({1'b0, r_in_x} == w_eff - 1'b1) begin
                    r_in_x <= '0;
                    r_in_y <= r_in_y + 1'b1;
                end else begin
                    r_in_x <= r_in_x + 1'b1;
                end
            end else if (r_state == S_LOAD && out_free) begin
                if (frame_done) begin
                    r_in_pos  <= '0;
                    r_out_pos <= '0;
                    r_in_x    <= '0;
                    r_in_y    <= '0;
                    r_out_x   <= '0;
                    r_out_y   <= '0;
                end else begin
                    r_out_pos <= r_out_pos + 1'b1;
                    if ({1'b0, r_out_x} == w_eff - 1'b1) begin
                        r_out_x <= '0;
                        r_out_y <= r_out_y + 1'b1;
                    end else begin
                        r_out_x <= r_out_x + 1'b1;
                    end
                end
            end
            if (r_state == S_IDLE) begin
                r_dx <= -$signed({1'b0, r_eff});
                r_dy <= -$signed({1'b0, r_eff});
            end else if (r_state == S_CALC) begin
                if (r_dx == $signed({1'b0, r_eff})) begin
                    r_dx <= -$signed({1'b0, r_eff});
                    r_dy <= r_dy + 1'b1;
                end else begin
                    r_dx <= r_dx + 1'b1;
                end
            end
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    assign lane_ctrl.clear = in_acc && emit;
    assign lane_ctrl.acc   = r_rd_vld;
    assign lane_ctrl.step  = (r_state == S_DIV);

    assign out_ctrl.load = (r_state == S_LOAD) && out_free;
    assign out_ctrl.last = frame_done;

    for (genvar g = 0; g < NL; g++) begin : g_lane
        cebb_lane u_lane (
            .i_clk     (i_clk),
            .i_ctrl    (lane_ctrl),
            .i_pix     (r_rd_data[g*CH +: CH]),
            .i_divisor (divisor),
            .o_mean    (means[g*CH +: CH])
        );
    end

    cebb_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (out_ctrl),
        .i_means       (means),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/cebb_checker.sv =====
module cebb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A result held back by the sink keeps its valid.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A new result is only loaded while the input side is held off.
    a_load_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while input was open");

endmodule

bind clamped_edge_box_blur_core cebb_checker u_cebb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb.sv =====
module tb;

    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 1100;
    localparam int LONG_HOLD   = 3000;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_ITEMS  = 150;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic       OP_FLUSH  = 1'b1;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last;
    } t_blur_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // red_in, green_in, blue_in
    logic        s_axis_tuser = 1'b0; // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // red_out, green_out, blue_out
    logic        m_axis_tlast;        // frame_end
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;

    clamped_edge_box_blur_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the block: raw registers, positions and the pixels of the frame.
    logic [10:0] width_reg = 11'd1024;
    logic [10:0] height_reg = 11'd1024;
    logic [3:0]  radius_reg = 4'd3;
    int          in_pos = 0;
    int          out_pos = 0;
    logic [47:0] frame_px [int];

    t_blur_pixel expected_px [$];
    int  errors = 0;
    int  items_sent = 0;
    int  pixels_seen = 0;
    int  frames_seen = 0;
    int  cfg_writes = 0;
    bit  quiet = 1'b0;
    bit  long_hold_start = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > cebb_pkg::MAX_WIDTH) return cebb_pkg::MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > cebb_pkg::MAX_HEIGHT) return cebb_pkg::MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic int eff_radius();
        return (int'(radius_reg) > cebb_pkg::MAX_RADIUS) ? cebb_pkg::MAX_RADIUS
                                                         : int'(radius_reg);
    endfunction

    function automatic int frame_total();
        return eff_width() * eff_height();
    endfunction

    // Clamped window mean of one channel, summed directly over the stored frame.
    function automatic logic [15:0] window_mean(int k, int ch);
        int w;
        int h;
        int r;
        int x;
        int y;
        int cx;
        int cy;
        longint sum;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        x = k % w;
        y = k / w;
        sum = 0;
        for (int dy = -r; dy <= r; dy++) begin
            cy = y + dy;
            if (cy < 0) cy = 0;
            if (cy > h - 1) cy = h - 1;
            for (int dx = -r; dx <= r; dx++) begin
                cx = x + dx;
                if (cx < 0) cx = 0;
                if (cx > w - 1) cx = w - 1;
                sum += frame_px[cy * w + cx][ch * 16 +: 16];
            end
        end
        return 16'(sum / ((2 * r + 1) * (2 * r + 1)));
    endfunction

    task automatic predict_item(input logic op, input logic [47:0] data);
        int total;
        int delay;
        bit emit;
        t_blur_pixel res;
        total = frame_total();
        delay = eff_radius() * eff_width() + eff_radius();
        emit = 1'b0;
        if (op == cebb_pkg::OP_PIXEL && in_pos < total) begin
            frame_px[in_pos] = data;
            in_pos++;
            if (in_pos > delay && out_pos < total) emit = 1'b1;
        end else if (in_pos >= total && out_pos < total) begin
            emit = 1'b1;
        end
        if (emit) begin
            res.red   = window_mean(out_pos, 0);
            res.green = window_mean(out_pos, 1);
            res.blue  = window_mean(out_pos, 2);
            out_pos++;
            res.last = (out_pos >= total);
            if (res.last) begin
                in_pos = 0;
                out_pos = 0;
            end
            expected_px.push_back(res);
        end
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic op, input logic [47:0] data);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        predict_item(op, data);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_px.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        drain_results();
        // A pixel that gives no output may still be in flight.
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            cebb_pkg::CFG_WIDTH:  width_reg = val;
            cebb_pkg::CFG_HEIGHT: height_reg = val;
            cebb_pkg::CFG_RADIUS: radius_reg = val[3:0];
            default:    ;
        endcase
        if (idx != CFG_SPARE) begin
            in_pos = 0;
            out_pos = 0;
        end
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h,
                             input logic [3:0] r);
        write_reg(cebb_pkg::CFG_WIDTH, w);
        write_reg(cebb_pkg::CFG_HEIGHT, h);
        write_reg(cebb_pkg::CFG_RADIUS, r);
    endtask

    function automatic logic [47:0] pixel_value(bit extreme, int i);
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        if (extreme) begin
            case (i % 3)
                0: v = '1;
                1: v = '0;
                default: v = {16'hFFFF, 16'h0000, 16'h8001};
            endcase
        end
        return v;
    endfunction

    // Sends one frame; cut stops it early, pause_at drains mid-frame.
    task automatic play_frame(input bit extreme, input int cut, input int pause_at);
        int total;
        total = frame_total();
        for (int i = 0; i < total; i++) begin
            if (i == cut) return;
            if (i == pause_at) drain_results();
            if (!extreme && $urandom_range(0, 15) == 0)
                send_item(OP_FLUSH, 48'({$urandom, $urandom}));
            send_item(cebb_pkg::OP_PIXEL, pixel_value(extreme, i));
        end
        // Tail of the frame: flushes, and now and then a pixel that only drains.
        while (in_pos != 0) begin
            if ($urandom_range(0, 3) == 0)
                send_item(cebb_pkg::OP_PIXEL, 48'({$urandom, $urandom}));
            else send_item(OP_FLUSH, 48'({$urandom, $urandom}));
        end
    endtask

    task automatic test_directed();
        // Under the reset setting no output is due for thousands of pixels.
        for (int i = 0; i < 4; i++) send_item(cebb_pkg::OP_PIXEL, pixel_value(1'b1, i));
        send_item(OP_FLUSH, '0);
        write_reg(CFG_SPARE, 11'h7FF);
        set_frame(11'd0, 11'd0, 4'd0);
        play_frame(1'b1, -1, -1);
        send_item(OP_FLUSH, '1);
        set_frame(11'd3, 11'd2, 4'd1);
        play_frame(1'b1, -1, -1);
        set_frame(11'd2, 11'd1, 4'd15);
        play_frame(1'b1, -1, -1);
        send_item(OP_FLUSH, '0);
    endtask

    task automatic test_extreme_sizes();
        set_frame(11'd5, 11'd4, 4'd15);
        play_frame(1'b0, -1, -1);
        set_frame(11'd1, 11'd7, 4'd2);
        play_frame(1'b0, -1, -1);
    endtask

    task automatic test_output_hold();
        set_frame(11'd8, 11'd4, 4'd1);
        long_hold_start = 1'b1;
        play_frame(1'b0, -1, -1);
    endtask

    task automatic test_sender_pause();
        set_frame(11'd6, 11'd5, 4'd2);
        play_frame(1'b0, -1, 20);
    endtask

    task automatic test_random_frames();
        int start;
        logic [10:0] w;
        logic [10:0] h;
        logic [3:0] r;
        int cut;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (items_sent - start > RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            w = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 10));
            if ($urandom_range(0, 9) == 0) w = 11'($urandom_range(11, 40));
            h = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
            r = ($urandom_range(0, 2) != 0) ? 4'($urandom_range(0, 3))
                                            : 4'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, 11'($urandom));
            case ($urandom_range(0, 2))
                0: set_frame(w, h, r);
                1: begin
                    write_reg(cebb_pkg::CFG_RADIUS, r);
                    write_reg(cebb_pkg::CFG_HEIGHT, h);
                    write_reg(cebb_pkg::CFG_WIDTH, w);
                end
                default: begin
                    write_reg(cebb_pkg::CFG_HEIGHT, h);
                    write_reg(cebb_pkg::CFG_WIDTH, w);
                    write_reg(cebb_pkg::CFG_RADIUS, r);
                end
            endcase
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, frame_total()) : -1;
            play_frame(1'b0, cut, -1);
            if (cut < 0 && $urandom_range(0, 3) == 0) play_frame(1'b0, -1, -1);
        end
    endtask

    // Result side: compare each transaction, then choose the next ready level.
    always @(posedge i_clk) begin
        t_blur_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_px.size() == 0) begin
                $display("%0t: unexpected output data=%h last=%b", $time,
                         m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = expected_px.pop_front();
                pixels_seen++;
                if (m_axis_tlast) frames_seen++;
                if (m_axis_tdata[15:0] !== want.red) begin
                    $display("%0t: red expected %h actual %h", $time, want.red,
                             m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[31:16] !== want.green) begin
                    $display("%0t: green expected %h actual %h", $time, want.green,
                             m_axis_tdata[31:16]);
                    errors++;
                end
                if (m_axis_tdata[47:32] !== want.blue) begin
                    $display("%0t: blue expected %h actual %h", $time, want.blue,
                             m_axis_tdata[47:32]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: frame end expected %b actual %b", $time, want.last,
                             m_axis_tlast);
                    errors++;
                end
            end
        end
        if (long_hold_start) begin
            long_hold_start = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extreme_sizes();
        test_output_hold();
        test_sender_pause();
        test_random_frames();
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d input items, %0d output pixels, %0d frame ends,", items_sent,
                 pixels_seen, frames_seen);
        $display("and %0d register writes across edge, size and radius extremes.",
                 cfg_writes);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
